// ===== rtl/core/crxts_pkg.sv =====
// shared types and constants for the can receive filter and timestamper
// no dependencies; imported by crxts_ctrl, crxts_dpath and can_rx_filter_timestamper

package crxts_pkg;

    localparam int PAYLOAD_BYTES_DEF = 8;
    localparam int COUNTER_BITS_DEF  = 32;

    localparam int SAMPLE_W   = 32;
    localparam int STD_ID_W   = 12;
    localparam int IDENT_W    = 11;
    localparam int LEN_W      = 4;
    localparam int DATA_BYTES = 8;
    localparam int DATA_W     = DATA_BYTES * 8;
    localparam int TIME_W     = 64;
    localparam int REJ_W      = 32;
    localparam int CPM_W      = 8;

    localparam logic [CPM_W-1:0] CPM_RESET = 8'd72;

    // input packing
    localparam int IN_TDATA_W = 112;
    localparam int IN_TUSER_W = 3;

    // output packing
    localparam int OUT_TDATA_W = 176;
    localparam int OUT_TUSER_W = 2;

    typedef enum logic [1:0] {
        STATUS_TIME   = 2'd0,
        STATUS_ACCEPT = 2'd1,
        STATUS_REJECT = 2'd2
    } status_code_t;

    typedef struct packed {
        logic capture;
        logic div_step;
        logic rej_inc;
        logic rem_fold;
        logic total_update;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic reject;
        logic div_done;
    } sts_t;

endpackage

// ===== rtl/core/crxts_ctrl.sv =====
// sequencer for the can receive filter and timestamper
// depends on crxts_pkg; drives the command word of crxts_dpath

module crxts_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  crxts_pkg::sts_t   sts,
    output crxts_pkg::cmd_t   cmd
);
    import crxts_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_FOLD = 5'b00100,
        S_ADD  = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DIV;
                end
            end
            S_DIV:
            begin
                // rejected frames skip the time update entirely
                if (sts.reject)
                begin
                    cmd.rej_inc = 1'b1;
                    state_next  = S_OUT;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                    if (sts.div_done)
                    begin
                        state_next = S_FOLD;
                    end
                end
            end
            S_FOLD:
            begin
                cmd.rem_fold = 1'b1;
                state_next   = S_ADD;
            end
            S_ADD:
            begin
                cmd.total_update = 1'b1;
                state_next       = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/core/crxts_dpath.sv =====
// datapath: frame filter, restoring divider, time accumulator and result register
// depends on crxts_pkg; sequenced by crxts_ctrl

module crxts_dpath #(
    parameter int PAYLOAD_BYTES = crxts_pkg::PAYLOAD_BYTES_DEF,
    parameter int COUNTER_BITS  = crxts_pkg::COUNTER_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  crxts_pkg::cmd_t                     cmd,
    output crxts_pkg::sts_t                     sts,
    input  logic                                cfg_we,
    input  logic [crxts_pkg::CPM_W-1:0]         cfg_data,
    input  logic                                in_op,
    input  logic [crxts_pkg::SAMPLE_W-1:0]      in_cycle_count,
    input  logic                                in_is_extended,
    input  logic                                in_is_remote,
    input  logic [crxts_pkg::STD_ID_W-1:0]      in_std_ident,
    input  logic [crxts_pkg::LEN_W-1:0]         in_length_code,
    input  logic [crxts_pkg::DATA_W-1:0]        in_payload,
    output logic [1:0]                          out_status,
    output logic [crxts_pkg::IDENT_W-1:0]       out_frame_ident,
    output logic [crxts_pkg::LEN_W-1:0]         out_frame_length,
    output logic [crxts_pkg::DATA_W-1:0]        out_frame_payload,
    output logic [crxts_pkg::TIME_W-1:0]        out_time_us,
    output logic [crxts_pkg::REJ_W-1:0]         out_rejected_total
);
    import crxts_pkg::*;

    localparam int CNT_W = $clog2(COUNTER_BITS);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(PAYLOAD_BYTES);

    // persistent state
    logic [CPM_W-1:0]        cpm_reg;
    logic [COUNTER_BITS-1:0] last_sample_reg;
    logic [CPM_W-1:0]        carry_rem_reg;
    logic [TIME_W-1:0]       micro_total_reg;
    logic [REJ_W-1:0]        reject_count_reg;

    // per-item registers
    status_code_t            kind_reg;
    logic [COUNTER_BITS-1:0] sample_reg;
    logic [IDENT_W-1:0]      ident_reg;
    logic [LEN_W-1:0]        len_reg;
    logic [DATA_W-1:0]       data_reg;
    logic [CPM_W-1:0]        div_reg;
    logic [COUNTER_BITS-1:0] quot_reg;
    logic [CPM_W-1:0]        prem_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    carry_reg;

    // output register
    logic [1:0]              o_status_reg;
    logic [IDENT_W-1:0]      o_ident_reg;
    logic [LEN_W-1:0]        o_len_reg;
    logic [DATA_W-1:0]       o_data_reg;
    logic [TIME_W-1:0]       o_time_reg;
    logic [REJ_W-1:0]        o_rej_reg;

    // capture logic
    logic [COUNTER_BITS-1:0] in_sample;
    logic [COUNTER_BITS-1:0] delta;
    logic                    in_reject;
    status_code_t            in_kind;
    logic [LEN_W-1:0]        len_clamped;
    logic [DATA_W-1:0]       data_masked;
    logic [CPM_W-1:0]        div_eff;

    // divider and fold
    logic [CPM_W:0]          trial;
    logic                    trial_ge;
    logic [CPM_W:0]          trial_sub;
    logic [CPM_W:0]          fold_sum;
    logic                    fold_ge;
    logic [CPM_W:0]          fold_sub;

    assign in_sample = in_cycle_count[COUNTER_BITS-1:0];
    assign delta     = in_sample - last_sample_reg;
    assign in_reject = in_is_extended || in_is_remote || in_std_ident[STD_ID_W-1];
    assign div_eff   = (cpm_reg == '0) ? CPM_W'(1) : cpm_reg;

    always_comb
    begin
        if (!in_op)
        begin
            in_kind = STATUS_TIME;
        end
        else if (in_reject)
        begin
            in_kind = STATUS_REJECT;
        end
        else
        begin
            in_kind = STATUS_ACCEPT;
        end
    end

    assign len_clamped = (in_length_code > LEN_MAX) ? LEN_MAX : in_length_code;

    for (genvar b = 0; b < DATA_BYTES; b++)
    begin : g_mask
        assign data_masked[b*8 +: 8] =
            (LEN_W'(b) < len_clamped) ? in_payload[b*8 +: 8] : 8'h00;
    end

    assign trial     = {prem_reg, quot_reg[COUNTER_BITS-1]};
    assign trial_ge  = (trial >= {1'b0, div_reg});
    assign trial_sub = trial - {1'b0, div_reg};

    assign fold_sum  = {1'b0, carry_rem_reg} + {1'b0, prem_reg};
    assign fold_ge   = (fold_sum >= {1'b0, div_reg});
    assign fold_sub  = fold_sum - {1'b0, div_reg};

    assign sts.reject   = (kind_reg == STATUS_REJECT);
    assign sts.div_done = (cnt_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpm_reg          <= CPM_RESET;
            last_sample_reg  <= '0;
            carry_rem_reg    <= '0;
            micro_total_reg  <= '0;
            reject_count_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                cpm_reg <= cfg_data;
            end
            if (cmd.rej_inc)
            begin
                reject_count_reg <= reject_count_reg + REJ_W'(1);
            end
            if (cmd.rem_fold)
            begin
                carry_rem_reg <= fold_ge ? fold_sub[CPM_W-1:0] : fold_sum[CPM_W-1:0];
            end
            if (cmd.total_update)
            begin
                micro_total_reg <= micro_total_reg + TIME_W'(quot_reg) + TIME_W'(carry_reg);
                last_sample_reg <= sample_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg   <= in_kind;
            sample_reg <= in_sample;
            quot_reg   <= delta;
            prem_reg   <= '0;
            cnt_reg    <= CNT_W'(COUNTER_BITS - 1);
            div_reg    <= div_eff;
            if (in_kind == STATUS_ACCEPT)
            begin
                ident_reg <= in_std_ident[IDENT_W-1:0];
                len_reg   <= len_clamped;
                data_reg  <= data_masked;
            end
            else
            begin
                ident_reg <= '0;
                len_reg   <= '0;
                data_reg  <= '0;
            end
        end
        if (cmd.div_step)
        begin
            // one quotient bit per cycle, dividend shifts out as quotient shifts in
            prem_reg <= trial_ge ? trial_sub[CPM_W-1:0] : trial[CPM_W-1:0];
            quot_reg <= {quot_reg[COUNTER_BITS-2:0], trial_ge};
            cnt_reg  <= cnt_reg - CNT_W'(1);
        end
        if (cmd.rem_fold)
        begin
            carry_reg <= fold_ge;
        end
        if (cmd.out_load)
        begin
            o_status_reg <= kind_reg;
            o_ident_reg  <= ident_reg;
            o_len_reg    <= len_reg;
            o_data_reg   <= data_reg;
            o_time_reg   <= micro_total_reg;
            o_rej_reg    <= reject_count_reg;
        end
    end

    assign out_status         = o_status_reg;
    assign out_frame_ident    = o_ident_reg;
    assign out_frame_length   = o_len_reg;
    assign out_frame_payload  = o_data_reg;
    assign out_time_us        = o_time_reg;
    assign out_rejected_total = o_rej_reg;

endmodule

// ===== rtl/core/can_rx_filter_timestamper.sv =====
// top level of the can receive filter and microsecond timestamper
// depends on crxts_pkg, crxts_ctrl and crxts_dpath

// Takes one item at a time. A time tick or an accepted standard data frame
// advances a 64-bit microsecond total by the cycle-counter delta divided by
// cycles_per_microsecond, with the division remainder carried between items.
// Extended, remote or out-of-range identifier frames are dropped from the time
// path and counted. A tick or accepted frame runs the restoring divider, one
// quotient bit per cycle, then the remainder fold, total update and output
// load; a rejected frame goes from capture straight to the output load.
// The result sits in an output register, so a new item can be accepted while
// the previous result waits for m_axis_tready. Configuration writes are taken
// at any time and must only be issued while the block is idle.

module can_rx_filter_timestamper #(
    parameter int PAYLOAD_BYTES = crxts_pkg::PAYLOAD_BYTES_DEF,
    parameter int COUNTER_BITS  = crxts_pkg::COUNTER_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [crxts_pkg::CPM_W-1:0]          cfg_data,      // cycles_per_microsecond
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // cycle_count[31:0], std_ident[43:32], length_code[47:44], payload[111:48]
    input  logic [crxts_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // op[0], is_extended[1], is_remote[2]
    input  logic [crxts_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // frame_ident[10:0], frame_length[14:11], frame_payload[78:15],
    // time_us[142:79], rejected_total[174:143], zero pad[175]
    output logic [crxts_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // status[1:0]
    output logic [crxts_pkg::OUT_TUSER_W-1:0]    m_axis_tuser
);
    import crxts_pkg::*;

    cmd_t                cmd;
    sts_t                sts;
    logic [1:0]          o_status;
    logic [IDENT_W-1:0]  o_ident;
    logic [LEN_W-1:0]    o_len;
    logic [DATA_W-1:0]   o_data;
    logic [TIME_W-1:0]   o_time;
    logic [REJ_W-1:0]    o_rej;

    assign cfg_ready = 1'b1;

    crxts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    crxts_dpath #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES),
        .COUNTER_BITS  (COUNTER_BITS)
    ) u_dpath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .sts                (sts),
        .cfg_we             (cfg_valid & cfg_ready),
        .cfg_data           (cfg_data),
        .in_op              (s_axis_tuser[0]),
        .in_cycle_count     (s_axis_tdata[31:0]),
        .in_is_extended     (s_axis_tuser[1]),
        .in_is_remote       (s_axis_tuser[2]),
        .in_std_ident       (s_axis_tdata[43:32]),
        .in_length_code     (s_axis_tdata[47:44]),
        .in_payload         (s_axis_tdata[111:48]),
        .out_status         (o_status),
        .out_frame_ident    (o_ident),
        .out_frame_length   (o_len),
        .out_frame_payload  (o_data),
        .out_time_us        (o_time),
        .out_rejected_total (o_rej)
    );

    assign m_axis_tdata = {1'b0, o_rej, o_time, o_data, o_len, o_ident};
    assign m_axis_tuser = o_status;

endmodule
